@@ hdl/scp_pkg.sv @@
// Shared types and constants for the stereo channel strip with pan and peak meter.
// Holds the frame and result payload structs, register indexes, mode codes and the
// fixed-point constants of the pan law and meter decay. Depends on nothing.
package scp_pkg;

  localparam int SAMPLE_BITS    = 24;
  localparam int CFG_INDEX_BITS = 4;
  localparam int CFG_DATA_BITS  = 16;
  localparam int GAIN_BITS      = 16;
  localparam int GAIN_FRAC      = 14;
  localparam int GAIN_HALF      = 1 << (GAIN_FRAC - 1);

  // Register indexes of the configuration port.
  localparam logic [CFG_INDEX_BITS-1:0] CFG_INPUT_MODE   = 4'd0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_TRIM_GAIN    = 4'd1;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_CHANNEL_GAIN = 4'd2;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_PAN_POSITION = 4'd3;

  // Routing modes; every other code is silent.
  localparam logic [1:0] MODE_MONO   = 2'd1;
  localparam logic [1:0] MODE_STEREO = 2'd2;

  // Reset values of the configuration and pan gain registers.
  localparam logic [GAIN_BITS-1:0] UNITY_GAIN     = 16'd16384;
  localparam logic [GAIN_BITS-1:0] PAN_GAIN_RESET = 16'd11585;

  // Pan law: position limits and the quarter-sine polynomial in Q30.
  localparam logic signed [15:0] PAN_LIMIT = 16'sd16384;
  localparam logic [15:0]        PAN_FULL  = 16'd32768;
  localparam int PAN_W        = 32;
  localparam int SINE_FRAC    = 30;
  localparam int SINE_HALF    = 1 << (SINE_FRAC - 1);
  localparam int HORNER_STEPS = 4;
  localparam logic [PAN_W-1:0] POLY_COEF [HORNER_STEPS+1] = '{
    32'd172272, 32'd5026995, 32'd85569306, 32'd693598668, 32'd1686629713
  };

  // Meter decay: floor(peak * 3 / 5) as a multiply by a rounded-up reciprocal.
  localparam int DECAY_SHIFT = SAMPLE_BITS + 4;
  localparam logic [63:0] DECAY_MULT = ((64'd3 << DECAY_SHIFT) + 64'd4) / 64'd5;
  localparam logic [SAMPLE_BITS-1:0] SAMPLE_MAG_MAX = SAMPLE_BITS'(1) << (SAMPLE_BITS - 1);

  // Shared multiplier operand and product widths.
  localparam int MUL_W  = (DECAY_SHIFT + 1 > 33) ? DECAY_SHIFT + 1 : 33;
  localparam int PROD_W = 2 * MUL_W;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] first_sample;
    logic signed [SAMPLE_BITS-1:0] second_sample;
    logic                          second_valid;
    logic signed [SAMPLE_BITS-1:0] master_left;
    logic signed [SAMPLE_BITS-1:0] master_right;
    logic                          last_in_block;
  } scp_in_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] mix_left;
    logic signed [SAMPLE_BITS-1:0] mix_right;
    logic [SAMPLE_BITS-1:0]        meter_level;
  } scp_out_t;

endpackage

@@ hdl/stereo_channel_strip_pan_meter_top.sv @@
// Top level of the stereo channel strip: routing, trim, constant-power pan,
// mix onto the master bus and decaying peak meter, all on one shared multiplier.
// Depends on scp_pkg for payload types, register indexes and constants.

// One input transaction carries a frame; one output transaction returns the mixed
// pair and the meter value. A frame is routed by input_mode (silent, mono, stereo
// with the left copied when the second channel is missing), trimmed, saturated and
// measured, then weighted by the pan gains and added onto the master samples with
// saturation. On the last frame of a block the meter becomes the larger of 0.6 times
// its old value and the block's largest magnitude. Every product goes through a
// single registered multiplier under a small sequencer, so a frame occupies the block
// from acceptance until its result is loaded, and no new frame is taken before then:
// four products per frame plus the decay product and the result load; the load waits
// only while the previous result still waits in the output register.
// Writing channel_gain or pan_position recomputes both pan gains by evaluating the
// quarter-sine polynomial on the same multiplier; while this runs, no frame and no
// further register write is taken. New gains apply from the next frame. Register
// writes are accepted only while no frame is being processed.
module stereo_channel_strip_pan_meter_top (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  scp_pkg::scp_in_t                      in_data,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output scp_pkg::scp_out_t                     out_data,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [scp_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
  input  logic [scp_pkg::CFG_DATA_BITS-1:0]     cfg_data
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_TRIM_L,
    S_TRIM_R,
    S_PAN_L,
    S_PAN_R,
    S_MIX_R,
    S_DECAY,
    S_DONE,
    S_GAIN_SQ,
    S_GAIN_X2,
    S_GAIN_HMUL,
    S_GAIN_HSUB,
    S_GAIN_SIN,
    S_GAIN_SINR,
    S_GAIN_SCALE,
    S_GAIN_STORE
  } state_t;

  state_t state;

  // Configuration registers.
  logic [1:0]                           input_mode;
  logic [scp_pkg::GAIN_BITS-1:0]        trim_gain;
  logic [scp_pkg::GAIN_BITS-1:0]        channel_gain;
  logic signed [15:0]                   pan_position;

  // Meter and pan gain state.
  logic [scp_pkg::SAMPLE_BITS-1:0]      block_max;
  logic [scp_pkg::SAMPLE_BITS-1:0]      peak_hold;
  logic [scp_pkg::GAIN_BITS-1:0]        left_pan_gain;
  logic [scp_pkg::GAIN_BITS-1:0]        right_pan_gain;

  // Frame working registers.
  logic signed [scp_pkg::SAMPLE_BITS-1:0] src_l;
  logic signed [scp_pkg::SAMPLE_BITS-1:0] src_r;
  logic signed [scp_pkg::SAMPLE_BITS-1:0] master_l;
  logic signed [scp_pkg::SAMPLE_BITS-1:0] master_r;
  logic                                   last_frame;
  logic signed [scp_pkg::SAMPLE_BITS-1:0] trim_l;
  logic signed [scp_pkg::SAMPLE_BITS-1:0] trim_r;
  logic signed [scp_pkg::SAMPLE_BITS-1:0] mix_l;
  logic signed [scp_pkg::SAMPLE_BITS-1:0] mix_r;

  // Pan gain evaluation registers.
  logic [scp_pkg::PAN_W-1:0]            x_reg;
  logic [scp_pkg::PAN_W-1:0]            x2;
  logic [scp_pkg::PAN_W-1:0]            poly_t;
  logic [1:0]                           hcnt;
  logic                                 gain_side;

  // Shared multiplier.
  logic signed [scp_pkg::MUL_W-1:0]     mul_a;
  logic signed [scp_pkg::MUL_W-1:0]     mul_b;
  logic signed [scp_pkg::PROD_W-1:0]    prod;

  // Combinational helpers.
  logic signed [scp_pkg::SAMPLE_BITS-1:0] sel_l;
  logic signed [scp_pkg::SAMPLE_BITS-1:0] sel_r;
  logic signed [15:0]                     pan_clamped;
  logic [15:0]                            u_pos;
  logic [15:0]                            u_sel;
  logic [scp_pkg::PAN_W-1:0]              x_pan;
  logic signed [scp_pkg::PROD_W-1:0]      prod_round;
  logic signed [scp_pkg::SAMPLE_BITS-1:0] trim_sat;
  logic signed [scp_pkg::SAMPLE_BITS-1:0] master_sel;
  logic signed [scp_pkg::SAMPLE_BITS-1:0] mix_sat;
  logic [scp_pkg::SAMPLE_BITS-1:0]        mag_sel;
  logic [scp_pkg::SAMPLE_BITS-1:0]        max_sel;
  logic [scp_pkg::SAMPLE_BITS-1:0]        decayed;
  logic [scp_pkg::PROD_W-1:0]             g_sum;
  logic [scp_pkg::GAIN_BITS:0]            g_full;
  logic [scp_pkg::GAIN_BITS-1:0]          g_val;
  logic [2:0]                             poly_idx;
  logic                                   out_load;

  // Clamp to the signed sample range.
  function automatic logic signed [scp_pkg::SAMPLE_BITS-1:0] sat_sample(
    input logic signed [scp_pkg::PROD_W-1:0] v
  );
    logic signed [scp_pkg::PROD_W-1:0] hi;
    logic signed [scp_pkg::PROD_W-1:0] lo;
    hi = {{(scp_pkg::PROD_W - scp_pkg::SAMPLE_BITS + 1){1'b0}},
          {(scp_pkg::SAMPLE_BITS - 1){1'b1}}};
    lo = ~hi;
    if (v > hi) begin
      return hi[scp_pkg::SAMPLE_BITS-1:0];
    end else if (v < lo) begin
      return lo[scp_pkg::SAMPLE_BITS-1:0];
    end
    return v[scp_pkg::SAMPLE_BITS-1:0];
  endfunction

  // Round a Q14 product half up, flooring towards minus infinity.
  function automatic logic signed [scp_pkg::PROD_W-1:0] round_q14(
    input logic signed [scp_pkg::PROD_W-1:0] v
  );
    return (v + scp_pkg::PROD_W'(scp_pkg::GAIN_HALF)) >>> scp_pkg::GAIN_FRAC;
  endfunction

  function automatic logic [scp_pkg::SAMPLE_BITS-1:0] magnitude(
    input logic signed [scp_pkg::SAMPLE_BITS-1:0] v
  );
    return v[scp_pkg::SAMPLE_BITS-1] ? $unsigned(-v) : $unsigned(v);
  endfunction

  // Input routing by mode; unused mode codes are silent.
  always_comb begin
    unique case (input_mode)
      scp_pkg::MODE_MONO: begin
        sel_l = in_data.first_sample;
        sel_r = in_data.first_sample;
      end
      scp_pkg::MODE_STEREO: begin
        sel_l = in_data.first_sample;
        sel_r = in_data.second_valid ? in_data.second_sample : in_data.first_sample;
      end
      default: begin
        sel_l = '0;
        sel_r = '0;
      end
    endcase
  end

  // Pan angle: clamp the position, offset it to 0..32768 and mirror it for the left side.
  always_comb begin
    if (pan_position < -scp_pkg::PAN_LIMIT) begin
      pan_clamped = -scp_pkg::PAN_LIMIT;
    end else if (pan_position > scp_pkg::PAN_LIMIT) begin
      pan_clamped = scp_pkg::PAN_LIMIT;
    end else begin
      pan_clamped = pan_position;
    end
    u_pos = $unsigned(pan_clamped + scp_pkg::PAN_LIMIT);
    u_sel = gain_side ? (scp_pkg::PAN_FULL - u_pos) : u_pos;
    x_pan = {{(scp_pkg::PAN_W - 31){1'b0}}, u_sel, 15'b0};
  end

  // Operand selection for the shared multiplier.
  always_comb begin
    unique case (state)
      S_TRIM_L: begin
        mul_a = scp_pkg::MUL_W'(src_l);
        mul_b = scp_pkg::MUL_W'(trim_gain);
      end
      S_TRIM_R: begin
        mul_a = scp_pkg::MUL_W'(src_r);
        mul_b = scp_pkg::MUL_W'(trim_gain);
      end
      S_PAN_L: begin
        mul_a = scp_pkg::MUL_W'(trim_l);
        mul_b = scp_pkg::MUL_W'(left_pan_gain);
      end
      S_PAN_R: begin
        mul_a = scp_pkg::MUL_W'(trim_r);
        mul_b = scp_pkg::MUL_W'(right_pan_gain);
      end
      S_MIX_R: begin
        mul_a = scp_pkg::MUL_W'(peak_hold);
        mul_b = scp_pkg::MUL_W'(scp_pkg::DECAY_MULT);
      end
      S_GAIN_SQ: begin
        mul_a = scp_pkg::MUL_W'(x_pan);
        mul_b = scp_pkg::MUL_W'(x_pan);
      end
      S_GAIN_HMUL: begin
        mul_a = scp_pkg::MUL_W'(x2);
        mul_b = scp_pkg::MUL_W'(poly_t);
      end
      S_GAIN_SIN: begin
        mul_a = scp_pkg::MUL_W'(x_reg);
        mul_b = scp_pkg::MUL_W'(poly_t);
      end
      S_GAIN_SCALE: begin
        mul_a = scp_pkg::MUL_W'(poly_t);
        mul_b = scp_pkg::MUL_W'(channel_gain);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // Post-processing of the registered product.
  always_comb begin
    prod_round = round_q14(prod);
    trim_sat   = sat_sample(prod_round);
    master_sel = (state == S_MIX_R) ? master_r : master_l;
    mix_sat    = sat_sample(scp_pkg::PROD_W'(master_sel) + prod_round);
    mag_sel    = (state == S_PAN_L) ? magnitude(trim_l) : magnitude(trim_r);
    max_sel    = (mag_sel > block_max) ? mag_sel : block_max;
    decayed    = prod[scp_pkg::DECAY_SHIFT +: scp_pkg::SAMPLE_BITS];
    g_sum      = $unsigned(prod) + scp_pkg::PROD_W'(scp_pkg::SINE_HALF);
    g_full     = g_sum[scp_pkg::SINE_FRAC +: scp_pkg::GAIN_BITS + 1];
    g_val      = g_full[scp_pkg::GAIN_BITS] ? '1 : g_full[scp_pkg::GAIN_BITS-1:0];
    poly_idx   = {1'b0, hcnt} + 3'd1;
  end

  assign in_stall  = (state != S_IDLE) || cfg_valid;
  assign cfg_ready = (state == S_IDLE);
  assign out_load  = (state == S_DONE) && (!out_valid || !out_stall);

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
    if (rst) begin
      state          <= S_IDLE;
      out_valid      <= 1'b0;
      input_mode     <= '0;
      trim_gain      <= scp_pkg::UNITY_GAIN;
      channel_gain   <= scp_pkg::UNITY_GAIN;
      pan_position   <= '0;
      block_max      <= '0;
      peak_hold      <= '0;
      left_pan_gain  <= scp_pkg::PAN_GAIN_RESET;
      right_pan_gain <= scp_pkg::PAN_GAIN_RESET;
      gain_side      <= 1'b0;
      hcnt           <= '0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (cfg_valid) begin
            unique case (cfg_index)
              scp_pkg::CFG_INPUT_MODE: begin
                input_mode <= cfg_data[1:0];
              end
              scp_pkg::CFG_TRIM_GAIN: begin
                trim_gain <= cfg_data;
              end
              scp_pkg::CFG_CHANNEL_GAIN: begin
                channel_gain <= cfg_data;
                gain_side    <= 1'b0;
                state        <= S_GAIN_SQ;
              end
              scp_pkg::CFG_PAN_POSITION: begin
                pan_position <= $signed(cfg_data);
                gain_side    <= 1'b0;
                state        <= S_GAIN_SQ;
              end
              default: begin
              end
            endcase
          end else if (in_valid) begin
            src_l      <= sel_l;
            src_r      <= sel_r;
            master_l   <= in_data.master_left;
            master_r   <= in_data.master_right;
            last_frame <= in_data.last_in_block;
            state      <= S_TRIM_L;
          end
        end
        S_TRIM_L: begin
          state <= S_TRIM_R;
        end
        S_TRIM_R: begin
          trim_l <= trim_sat;
          state  <= S_PAN_L;
        end
        S_PAN_L: begin
          trim_r    <= trim_sat;
          block_max <= max_sel;
          state     <= S_PAN_R;
        end
        S_PAN_R: begin
          mix_l     <= mix_sat;
          block_max <= max_sel;
          state     <= S_MIX_R;
        end
        S_MIX_R: begin
          mix_r <= mix_sat;
          state <= last_frame ? S_DECAY : S_DONE;
        end
        S_DECAY: begin
          peak_hold <= (decayed > block_max) ? decayed : block_max;
          block_max <= '0;
          state     <= S_DONE;
        end
        S_DONE: begin
          if (out_load) begin
            out_data.mix_left    <= mix_l;
            out_data.mix_right   <= mix_r;
            out_data.meter_level <= peak_hold;
            state                <= S_IDLE;
          end
        end
        S_GAIN_SQ: begin
          x_reg <= x_pan;
          state <= S_GAIN_X2;
        end
        S_GAIN_X2: begin
          x2     <= prod[scp_pkg::SINE_FRAC +: scp_pkg::PAN_W];
          poly_t <= scp_pkg::POLY_COEF[0];
          hcnt   <= '0;
          state  <= S_GAIN_HMUL;
        end
        S_GAIN_HMUL: begin
          state <= S_GAIN_HSUB;
        end
        S_GAIN_HSUB: begin
          poly_t <= scp_pkg::POLY_COEF[poly_idx] - prod[scp_pkg::SINE_FRAC +: scp_pkg::PAN_W];
          if (hcnt == 2'(scp_pkg::HORNER_STEPS - 1)) begin
            state <= S_GAIN_SIN;
          end else begin
            hcnt  <= hcnt + 2'd1;
            state <= S_GAIN_HMUL;
          end
        end
        S_GAIN_SIN: begin
          state <= S_GAIN_SINR;
        end
        S_GAIN_SINR: begin
          poly_t <= prod[scp_pkg::SINE_FRAC +: scp_pkg::PAN_W];
          state  <= S_GAIN_SCALE;
        end
        S_GAIN_SCALE: begin
          state <= S_GAIN_STORE;
        end
        S_GAIN_STORE: begin
          if (gain_side) begin
            left_pan_gain <= g_val;
            state         <= S_IDLE;
          end else begin
            right_pan_gain <= g_val;
            gain_side      <= 1'b1;
            state          <= S_GAIN_SQ;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  // An accepted frame always starts the trim sequence on the next cycle.
  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> (state == S_TRIM_L))
    else $error("accepted frame did not start processing");

  // The meter and the running block maximum never exceed the largest sample magnitude.
  a_peak_range: assert property (@(posedge clk) disable iff (rst)
    peak_hold <= scp_pkg::SAMPLE_MAG_MAX)
    else $error("peak hold out of range");

  a_block_max_range: assert property (@(posedge clk) disable iff (rst)
    block_max <= scp_pkg::SAMPLE_MAG_MAX)
    else $error("block maximum out of range");

  // Pan gains change only when the gain sequence stores them.
  a_gain_update: assert property (@(posedge clk) disable iff (rst)
    (!$stable(left_pan_gain) || !$stable(right_pan_gain)) |-> ($past(state) == S_GAIN_STORE))
    else $error("pan gain changed outside the gain sequence");

  // A result is loaded only when the output register is free or being emptied.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE && out_valid && out_stall) |=> (state == S_DONE))
    else $error("result loaded over a stalled result");
`endif

endmodule
